@@ hw/rtl/bmfc_pkg.sv @@
// Shared types and constants for the four-connected binary morphology unit.
package bmfc_pkg;

    localparam int unsigned PIX_W   = 8;
    localparam int unsigned ROWS_W  = 16;
    localparam int unsigned FCOLS_W = 11;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned ADDR_W  = 4;

    localparam logic [PIX_W-1:0] PIX_HIGH = 8'd255;
    localparam logic [PIX_W-1:0] PIX_LOW  = 8'd0;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_FRAME_COLS = 2'd0;
    localparam logic [1:0] REG_FRAME_ROWS = 2'd1;
    localparam logic [1:0] REG_PASS_MODE  = 2'd2;

    localparam logic [FCOLS_W-1:0] RST_FRAME_COLS = 11'd640;
    localparam logic [ROWS_W-1:0]  RST_FRAME_ROWS = 16'd480;

    localparam logic [MODE_W-1:0] MODE_SHRINK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GROW    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CASCADE = 2'd2;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic {
        KIND_SHRINK = 1'b0,
        KIND_GROW   = 1'b1
    } t_kind;

    // shrink, grow, grow, shrink; bit s is the kind of stage s
    localparam logic [3:0] CASCADE_KIND = 4'b0110;

    // one step between stages: vld = a step happened, pix = it carries a pixel
    typedef struct packed {
        logic             vld;
        logic             pix;
        logic [PIX_W-1:0] data;
        logic             fend;
    } t_token;

endpackage

@@ hw/rtl/bmfc_stage.sv @@
// One morphology stage: history memories, window compare and stream counters.
module bmfc_stage #(
    parameter int unsigned MAX_COLS = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_clear,
    input  logic [$clog2(MAX_COLS+1)-1:0]       i_cols,
    input  logic [bmfc_pkg::ROWS_W-1:0]         i_rows,
    input  bmfc_pkg::t_kind                     i_kind,
    input  bmfc_pkg::t_token                    i_tok,
    output bmfc_pkg::t_token                    o_tok
);
    import bmfc_pkg::*;

    localparam int unsigned AW    = $clog2(2*MAX_COLS+2);
    localparam int unsigned DEPTH = 1 << AW;
    localparam int unsigned CW    = $clog2(MAX_COLS+1);
    localparam int unsigned LW    = $clog2(MAX_COLS+2);
    localparam int unsigned XW    = $clog2(MAX_COLS);

    logic [PIX_W-1:0] mem_a [DEPTH];
    logic [PIX_W-1:0] mem_b [DEPTH];

    logic [AW-1:0]     r_wp;
    logic [LW-1:0]     r_lag;
    logic [XW-1:0]     r_col;
    logic [ROWS_W-1:0] r_row;

    logic             r_c_vld, r_c_emit, r_c_border, r_c_end;
    logic [PIX_W-1:0] r_c_dn, r_ctr, r_rt, r_up, r_left;
    logic             r_o_vld, r_o_pix, r_o_fend;
    logic [PIX_W-1:0] r_o_data;

    logic           step, pix, ready, row_last, col_last, border;
    logic [LW-1:0]  lag1, n_lag;
    logic [AW-1:0]  wp1, rp, rt_a, up_a;
    logic [CW:0]    colp1;
    logic [ROWS_W:0] rowp1;

    always_comb begin
        step     = i_en && i_tok.vld;
        pix      = i_tok.pix;
        lag1     = pix ? r_lag + LW'(1) : r_lag;
        wp1      = pix ? r_wp + AW'(1) : r_wp;
        rowp1    = {1'b0, r_row} + (ROWS_W+1)'(1);
        colp1    = (CW+1)'(r_col) + (CW+1)'(1);
        row_last = rowp1 >= {1'b0, i_rows};
        col_last = colp1 >= (CW+1)'(i_cols);
        ready    = pix ? (lag1 > LW'(i_cols)) : ((r_lag != '0) && row_last);
        border   = (r_row == '0) || row_last || (r_col == '0) || col_last;
        n_lag    = ready ? lag1 - LW'(1) : lag1;
        rp       = wp1 - AW'(lag1);
        rt_a     = rp + AW'(1);
        up_a     = rp - AW'(i_cols);
    end

    // history store, duplicated so that three entries can be read per step
    always_ff @(posedge i_clk) begin
        if (step && pix) begin
            mem_a[r_wp] <= i_tok.data;
            mem_b[r_wp] <= i_tok.data;
        end
        if (i_en) begin
            r_ctr <= mem_a[rp];
            r_rt  <= mem_a[rt_a];
            r_up  <= mem_b[up_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_wp    <= '0;
            r_lag   <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_c_vld <= i_tok.vld;
            if (step) begin
                r_wp  <= wp1;
                r_lag <= n_lag;
                if (ready) begin
                    if (col_last) begin
                        r_col <= '0;
                        r_row <= row_last ? '0 : rowp1[ROWS_W-1:0];
                    end else begin
                        r_col <= colp1[XW-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_emit   <= ready;
            r_c_border <= border;
            r_c_end    <= row_last && col_last;
            r_c_dn     <= i_tok.data;
        end
    end

    // compute: left neighbour is the previous emitted centre
    logic             differs;
    logic [PIX_W-1:0] val;

    always_comb begin
        differs = (r_up != r_ctr) || (r_c_dn != r_ctr) || (r_left != r_ctr) ||
                  (r_rt != r_ctr);
        val     = r_ctr;
        if (!r_c_border && differs) begin
            if (i_kind == KIND_SHRINK && r_ctr == PIX_HIGH) val = PIX_LOW;
            if (i_kind == KIND_GROW && r_ctr == PIX_LOW)    val = PIX_HIGH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_o_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_pix  <= r_c_vld && r_c_emit;
            r_o_data <= val;
            r_o_fend <= r_c_end;
            if (r_c_vld && r_c_emit) begin
                r_left <= r_ctr;
            end
        end
    end

    assign o_tok.vld  = r_o_vld;
    assign o_tok.pix  = r_o_pix;
    assign o_tok.data = r_o_data;
    assign o_tok.fend = r_o_fend;

endmodule

@@ hw/rtl/binary_morphology_four_conn_unit.sv @@
// Top level of the streaming four-connected binary erosion / dilation unit.
//
// Grey pixels enter in raster order, one request per clock, and leave in the same
// order after the chosen passes: shrink only, grow only, or the cascade shrink,
// grow, grow, shrink (first STAGES stages). Only pixels of exactly 0 or 255 are
// touched; border rows and columns pass unchanged. Each stage holds back
// frame_cols+1 pixels, so after a frame send drain requests (op = 1) to flush the
// last row; a drain with nothing pending gives no result. Throughput is one
// request per clock while no result waits at the output; each stage keeps its
// pixel history in a pair of synchronous RAMs (write pointer plus centre, right
// and up reads) and registers each pixel in its compare and output registers,
// and the top adds an output register behind the last active stage.
// The whole pipe freezes while a result waits at the output.
// Any register write restarts the stream and drops pending pixels; write only
// while idle. Registers: 0x0 frame_cols, 0x4 frame_rows, 0x8 pass_mode.
module binary_morphology_four_conn_unit #(
    parameter int unsigned MAX_COLS = 1024,
    parameter int unsigned STAGES   = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_op,
    input  logic [bmfc_pkg::PIX_W-1:0]        i_pixel_in,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [bmfc_pkg::PIX_W-1:0]        o_pixel_out,
    output logic                              o_frame_end,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bmfc_pkg::ADDR_W-1:0]       paddr,
    input  logic [bmfc_pkg::DATA_W-1:0]       pwdata,
    output logic [bmfc_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);
    import bmfc_pkg::*;

    localparam int unsigned CW = $clog2(MAX_COLS+1);

    // configuration registers
    logic [FCOLS_W-1:0] r_frame_cols;
    logic [ROWS_W-1:0]  r_frame_rows;
    logic [MODE_W-1:0]  r_pass_mode;
    logic [1:0]         reg_idx;
    logic               wr_req, clear;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_req  = psel && penable && pwrite;
    assign clear   = wr_req && (reg_idx == REG_FRAME_COLS || reg_idx == REG_FRAME_ROWS ||
                                reg_idx == REG_PASS_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_cols <= RST_FRAME_COLS;
            r_frame_rows <= RST_FRAME_ROWS;
            r_pass_mode  <= MODE_CASCADE;
        end else if (wr_req) begin
            case (reg_idx)
                REG_FRAME_COLS: r_frame_cols <= pwdata[FCOLS_W-1:0];
                REG_FRAME_ROWS: r_frame_rows <= pwdata[ROWS_W-1:0];
                REG_PASS_MODE:  r_pass_mode  <= pwdata[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FRAME_COLS: prdata = DATA_W'(r_frame_cols);
            REG_FRAME_ROWS: prdata = DATA_W'(r_frame_rows);
            REG_PASS_MODE:  prdata = DATA_W'(r_pass_mode);
            default:        prdata = '0;
        endcase
    end

    // effective geometry: zero acts as one, width clamps to MAX_COLS
    logic [CW-1:0]     eff_cols;
    logic [ROWS_W-1:0] eff_rows;
    logic              single;

    always_comb begin
        if (r_frame_cols == '0) begin
            eff_cols = CW'(1);
        end else if (32'(r_frame_cols) > 32'(MAX_COLS)) begin
            eff_cols = CW'(MAX_COLS);
        end else begin
            eff_cols = CW'(r_frame_cols);
        end
        eff_rows = (r_frame_rows == '0) ? ROWS_W'(1) : r_frame_rows;
        single   = (r_pass_mode == MODE_SHRINK) || (r_pass_mode == MODE_GROW);
    end

    // pipeline advances whenever the output register can take a result
    logic r_o_vld;
    logic en;

    assign en      = !r_o_vld || i_ready;
    assign o_ready = en;

    t_token tok [STAGES+1];

    assign tok[0].vld  = i_valid;
    assign tok[0].pix  = (i_op == OP_PIXEL);
    assign tok[0].data = i_pixel_in;
    assign tok[0].fend = 1'b0;

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        t_kind kind;
        assign kind = single ? t_kind'(r_pass_mode[0]) : t_kind'(CASCADE_KIND[s]);

        bmfc_stage #(
            .MAX_COLS (MAX_COLS)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_clear (clear),
            .i_cols  (eff_cols),
            .i_rows  (eff_rows),
            .i_kind  (kind),
            .i_tok   (tok[s]),
            .o_tok   (tok[s+1])
        );
    end

    // single-pass modes take the first stage, the cascade the last
    t_token last_tok;
    assign last_tok = single ? tok[1] : tok[STAGES];

    logic [PIX_W-1:0] r_o_pix;
    logic             r_o_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= last_tok.vld && last_tok.pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_pix <= last_tok.data;
            r_o_end <= last_tok.fend;
        end
    end

    assign o_valid     = r_o_vld;
    assign o_pixel_out = r_o_pix;
    assign o_frame_end = r_o_end;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the four-connected binary morphology unit.
module testbench;
    import bmfc_pkg::*;

    localparam int COL_LIMIT = 1024;
    localparam int RING      = 2 * COL_LIMIT + 2;
    localparam int CHAIN     = 4;

    typedef struct {
        logic [PIX_W-1:0] pix;
        logic             fend;
    } t_result;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic                in_op;
    logic [PIX_W-1:0]    in_pix;
    logic                out_valid;
    logic                out_ready;
    logic [PIX_W-1:0]    out_pix;
    logic                out_fend;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // idle odds in percent for each side
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned fail_count;

    // predictor copy of the registers and per-stage history
    int unsigned      cfg_cols;
    int unsigned      cfg_rows;
    int unsigned      cfg_mode;
    logic [PIX_W-1:0] hist [CHAIN][RING];
    int unsigned      wr_pos [CHAIN];
    int unsigned      pend [CHAIN];
    int unsigned      col_at [CHAIN];
    int unsigned      row_at [CHAIN];

    t_result expected_pixels [$];

    binary_morphology_four_conn_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_ready     (in_ready),
        .i_op        (in_op),
        .i_pixel_in  (in_pix),
        .o_valid     (out_valid),
        .i_ready     (out_ready),
        .o_pixel_out (out_pix),
        .o_frame_end (out_fend),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // generous fixed limit on the whole run
    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int unsigned eff_cols();
        if (cfg_cols == 0) return 1;
        if (cfg_cols > COL_LIMIT) return COL_LIMIT;
        return cfg_cols;
    endfunction

    function automatic int unsigned eff_rows();
        return (cfg_rows == 0) ? 1 : cfg_rows;
    endfunction

    function automatic int unsigned ring_at(int unsigned base, int unsigned up,
                                            int unsigned down);
        return (base + up + RING - (down % RING)) % RING;
    endfunction

    function automatic void clear_history();
        for (int s = 0; s < CHAIN; s++) begin
            for (int k = 0; k < RING; k++) hist[s][k] = PIX_LOW;
            wr_pos[s] = 0;
            pend[s]   = 0;
            col_at[s] = 0;
            row_at[s] = 0;
        end
    endfunction

    // one stage: takes a pixel or a bubble, may pass one pixel on
    function automatic void morph_stage(int s, t_kind kind, inout logic is_pix,
                                        inout logic [PIX_W-1:0] v, output logic fend);
        int unsigned cols;
        int unsigned rows;
        int unsigned o;
        int unsigned r;
        int unsigned c;
        logic        rdy;
        logic        differs;
        logic [PIX_W-1:0] cur;
        logic [PIX_W-1:0] res;
        cols = eff_cols();
        rows = eff_rows();
        fend = 1'b0;
        if (is_pix) begin
            hist[s][wr_pos[s]] = v;
            wr_pos[s] = (wr_pos[s] + 1) % RING;
            if (pend[s] < RING - 1) pend[s]++;
            rdy = pend[s] >= cols + 1;
        end else begin
            rdy = pend[s] > 0 && row_at[s] + 1 >= rows;
        end
        is_pix = rdy;
        if (!rdy) return;
        o = ring_at(wr_pos[s], 0, pend[s]);
        r = row_at[s];
        c = col_at[s];
        cur = hist[s][o];
        res = cur;
        if (!(r == 0 || r + 1 >= rows || c == 0 || c + 1 >= cols)) begin
            differs = hist[s][ring_at(o, 0, cols)] != cur || hist[s][ring_at(o, cols, 0)] != cur
                   || hist[s][ring_at(o, 0, 1)] != cur || hist[s][ring_at(o, 1, 0)] != cur;
            if (kind == KIND_SHRINK && cur == PIX_HIGH && differs) res = PIX_LOW;
            if (kind == KIND_GROW && cur == PIX_LOW && differs) res = PIX_HIGH;
        end
        fend = r + 1 >= rows && c + 1 >= cols;
        v = res;
        c++;
        if (c >= cols) begin
            c = 0;
            r++;
            if (r >= rows) r = 0;
        end
        col_at[s] = c;
        row_at[s] = r;
        pend[s]--;
    endfunction

    function automatic void predict_request(logic op, logic [PIX_W-1:0] pix);
        logic             live;
        logic             fend;
        logic [PIX_W-1:0] v;
        int               n;
        t_kind            kind;
        t_result          res;
        live = (op == OP_PIXEL);
        v    = pix;
        fend = 1'b0;
        n    = (cfg_mode == MODE_SHRINK || cfg_mode == MODE_GROW) ? 1 : CHAIN;
        for (int s = 0; s < n; s++) begin
            kind = (n == 1) ? t_kind'(cfg_mode[0]) : t_kind'(CASCADE_KIND[s]);
            morph_stage(s, kind, live, v, fend);
        end
        if (live) begin
            res.pix  = v;
            res.fend = fend;
            expected_pixels = {expected_pixels, res};
        end
    endfunction

    // ---------------------------------------------------------------- checker

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk) begin
        t_result want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_pixels.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result pixel %0d frame_end %0b", out_pix, out_fend);
            end else begin
                want = expected_pixels.pop_front();
                if (want.pix !== out_pix || want.fend !== out_fend) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: want pixel %0d end %0b, got pixel %0d end %0b",
                                 want.pix, want.fend, out_pix, out_fend);
                end
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    // sends one request, leaving valid high for a following one
    task automatic send_request(logic op, logic [PIX_W-1:0] pix);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_op    <= op;
        in_pix   <= pix;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_request(op, pix);
    endtask

    // lower valid, let every result out and let drains with no result settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int unsigned value);
        int unsigned mask;
        mask = (idx == REG_FRAME_COLS) ? 32'h7FF : (idx == REG_FRAME_ROWS) ? 32'hFFFF : 32'h3;
        wait_idle();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_FRAME_COLS: cfg_cols = value & mask;
            REG_FRAME_ROWS: cfg_rows = value & mask;
            default:        cfg_mode = value & mask;
        endcase
        clear_history();
        // read back
        @(posedge clk);
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if ((prdata & mask) !== (value & mask)) begin
            fail_count++;
            if (fail_count <= 10)
                $display("register %0d read %0h, want %0h", idx, prdata, value & mask);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_frame(int unsigned cols, int unsigned rows, int unsigned mode);
        write_reg(REG_FRAME_COLS, cols);
        write_reg(REG_FRAME_ROWS, rows);
        write_reg(REG_PASS_MODE, mode);
    endtask

    // mostly clean black and white with some grey
    function automatic logic [PIX_W-1:0] pick_pixel();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 45) return PIX_LOW;
        if (r < 90) return PIX_HIGH;
        return PIX_W'($urandom_range(255));
    endfunction

    task automatic send_pixels(int unsigned n);
        repeat (n) send_request(OP_PIXEL, pick_pixel());
    endtask

    // enough drains to flush every active stage
    task automatic send_drains(int unsigned cols);
        int unsigned n;
        n = (cfg_mode == MODE_SHRINK || cfg_mode == MODE_GROW) ? 1 : CHAIN;
        repeat (n * (cols + 1) + 2) send_request(OP_DRAIN, PIX_W'($urandom_range(255)));
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_reset_defaults();
        // 640 wide after reset: nothing comes out, drains give no result
        send_pixels(10);
        send_request(OP_DRAIN, PIX_HIGH);
        send_request(OP_DRAIN, PIX_LOW);
    endtask

    task automatic test_each_mode();
        for (int m = 0; m < 4; m++) begin
            set_frame(5, 4, m);
            send_pixels(20);
            send_drains(5);
        end
    endtask

    task automatic test_degenerate_sizes();
        set_frame(0, 2, MODE_CASCADE);     // zero width acts as one column
        send_pixels(2);
        send_drains(1);
        set_frame(4, 0, MODE_GROW);        // zero height acts as one row
        send_pixels(4);
        send_drains(4);
        set_frame(3, 65535, MODE_SHRINK);  // tallest frame, never finished
        send_pixels(12);
        send_request(OP_DRAIN, PIX_LOW);
    endtask

    task automatic test_widest();
        // wider than the line store allows: clamps to the full width, so the
        // first results appear once a whole row plus one pixel is held
        set_frame(2047, 2, MODE_GROW);
        send_pixels(COL_LIMIT + 4);
    endtask

    task automatic test_random_frames(int unsigned budget);
        int unsigned sent;
        int unsigned cols;
        int unsigned rows;
        int unsigned kind;
        sent = 0;
        while (sent < budget) begin
            cols = $urandom_range(10, 3);
            rows = $urandom_range(8, 3);
            set_frame(cols, rows, $urandom_range(3));
            kind = $urandom_range(9);
            if (kind == 0) begin
                // noise: arbitrary pixels and drains
                repeat (30) send_request(1'($urandom_range(1)), PIX_W'($urandom_range(255)));
                sent += 30;
            end else if (kind == 1) begin
                // frame cut short, then drained
                send_pixels($urandom_range(cols * rows - 1, 1));
                send_drains(cols);
                sent += cols * rows;
            end else if (kind == 2) begin
                // two frames back to back with no drain between
                send_pixels(2 * cols * rows);
                send_drains(cols);
                sent += 2 * cols * rows;
            end else begin
                send_pixels(cols * rows);
                send_drains(cols);
                sent += cols * rows;
            end
        end
    endtask

    initial begin
        fail_count    = 0;
        send_idle_pct = 28;
        recv_idle_pct = 85;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_op     <= OP_PIXEL;
        in_pix    <= PIX_LOW;
        out_ready <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        cfg_cols = RST_FRAME_COLS;
        cfg_rows = RST_FRAME_ROWS;
        cfg_mode = MODE_CASCADE;
        clear_history();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_each_mode();
        test_degenerate_sizes();
        test_random_frames(40);
        send_idle_pct = 85;
        recv_idle_pct = 28;
        test_widest();
        test_random_frames(40);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_frames(40);

        wait_idle();
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
